/* src/host_port_path_parser_macros.svh */
// Assertion macros used by the host path parser top level.
`ifndef HOST_PORT_PATH_PARSER_MACROS_SVH
`define HOST_PORT_PATH_PARSER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HPPP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("host path parser check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HPPP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("host path parser check failed");

`endif

/* src/hppp_pkg.sv */
// Types, codes and character classes for the host path parser.
package hppp_pkg;

   localparam int HOST_LEN_W = 8;
   localparam int PORT_W     = 17;
   localparam int CSR_W      = 16;

   localparam logic [CSR_W-1:0]  DEFAULT_PORT_RESET = 16'd5900;
   localparam logic [PORT_W-1:0] DISPLAY_MAX        = 17'd99;

   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_HOST    = 3'd1;
   localparam logic [2:0] PH_BRHOST  = 3'd2;
   localparam logic [2:0] PH_AFTERBR = 3'd3;
   localparam logic [2:0] PH_COLON   = 3'd4;
   localparam logic [2:0] PH_DIGITS  = 3'd5;

   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_DASH     = 8'h2D;
   localparam logic [7:0] CHAR_UNDER    = 8'h5F;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                  path_ok;
      logic                  host_offset;
      logic [HOST_LEN_W-1:0] host_length;
      logic                  use_localhost;
      logic [PORT_W-1:0]     port_value;
   } rsp_type;

   // Summary of the path state after the current character.
   typedef struct packed {
      logic [2:0]            phase;
      logic                  bracketed;
      logic                  host_empty;
      logic                  host_bad;
      logic                  failed;
      logic                  too_long;
      logic                  double_colon;
      logic                  digits_empty;
      logic [HOST_LEN_W-1:0] host_length;
      logic [PORT_W-1:0]     port_accum;
   } status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_host_char(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             is_digit(c) || (c == CHAR_DOT) || (c == CHAR_DASH) ||
             (c == CHAR_UNDER) || (c == CHAR_COLON);
   endfunction

endpackage

/* src/hppp_tracker.sv */
// Per-character path state registers and their update logic.
module hppp_tracker import hppp_pkg::*; #(
   parameter int MAX_HOST_CHARS  = 255,
   parameter int MAX_PORT_DIGITS = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       step_last,
   input  logic [7:0] step_char,
   output status_type status
);

   localparam int PATH_LIMIT = MAX_HOST_CHARS + MAX_PORT_DIGITS + 5;
   localparam int POS_W      = $clog2(PATH_LIMIT + 2);
   localparam int HC_W       = $clog2(MAX_HOST_CHARS + 2);
   localparam int DC_W       = $clog2(MAX_PORT_DIGITS + 1);

   logic [POS_W-1:0]  position_ff, position_in;
   logic [2:0]        phase_ff, phase_in;
   logic              bracketed_ff, bracketed_in;
   logic [HC_W-1:0]   host_count_ff, host_count_in;
   logic              double_colon_ff, double_colon_in;
   logic [DC_W-1:0]   digit_count_ff, digit_count_in;
   logic [PORT_W-1:0] port_accum_ff, port_accum_in;
   logic              failed_ff, failed_in;
   logic              host_bad_ff, host_bad_in;

   logic [HC_W-1:0]       host_count_inc;
   logic                  host_char_bad;
   logic                  digit_bad;
   logic [PORT_W-1:0]     accum_step;
   logic [POS_W-1:0]      colon_place;
   logic [HC_W+7:0]       host_count_wide;

   always_comb begin
      host_count_inc = (host_count_ff <= HC_W'(MAX_HOST_CHARS)) ?
                       host_count_ff + HC_W'(1) : host_count_ff;
      host_char_bad  = (host_count_inc > HC_W'(MAX_HOST_CHARS)) ||
                       !is_host_char(step_char);
      digit_bad      = !is_digit(step_char) ||
                       (digit_count_ff >= DC_W'(MAX_PORT_DIGITS));
      accum_step     = (port_accum_ff << 3) + (port_accum_ff << 1) +
                       PORT_W'(step_char[3:0]);
      colon_place    = POS_W'(host_count_ff) + POS_W'(3);

      position_in     = (position_ff <= POS_W'(PATH_LIMIT)) ?
                        position_ff + POS_W'(1) : position_ff;
      phase_in        = phase_ff;
      bracketed_in    = bracketed_ff;
      host_count_in   = host_count_ff;
      double_colon_in = double_colon_ff;
      digit_count_in  = digit_count_ff;
      port_accum_in   = port_accum_ff;
      failed_in       = failed_ff;
      host_bad_in     = host_bad_ff;

      case (phase_ff)
         PH_START: begin
            if (step_char == CHAR_LBRACKET) begin
               bracketed_in = 1'b1;
               phase_in     = PH_BRHOST;
            end else if (step_char == CHAR_COLON) begin
               failed_in = 1'b1;
               phase_in  = PH_COLON;
            end else begin
               host_count_in = host_count_inc;
               host_bad_in   = host_bad_ff | host_char_bad;
               phase_in      = PH_HOST;
            end
         end
         PH_HOST: begin
            if (step_char == CHAR_COLON) begin
               phase_in = PH_COLON;
            end else begin
               host_count_in = host_count_inc;
               host_bad_in   = host_bad_ff | host_char_bad;
            end
         end
         PH_BRHOST: begin
            if (step_char == CHAR_RBRACKET) begin
               phase_in = PH_AFTERBR;
            end else begin
               host_count_in = host_count_inc;
               host_bad_in   = host_bad_ff | host_char_bad;
            end
         end
         PH_AFTERBR: begin
            if (step_char == CHAR_COLON) begin
               phase_in = PH_COLON;
               if (position_in != colon_place) begin
                  failed_in = 1'b1;
               end
            end
         end
         PH_COLON: begin
            phase_in = PH_DIGITS;
            if (step_char == CHAR_COLON) begin
               double_colon_in = 1'b1;
            end else if (digit_bad) begin
               failed_in = 1'b1;
            end else begin
               digit_count_in = digit_count_ff + DC_W'(1);
               port_accum_in  = accum_step;
            end
         end
         default: begin
            if (digit_bad) begin
               failed_in = 1'b1;
            end else begin
               digit_count_in = digit_count_ff + DC_W'(1);
               port_accum_in  = accum_step;
            end
         end
      endcase

      host_count_wide     = {8'd0, host_count_in};
      status.phase        = phase_in;
      status.bracketed    = bracketed_in;
      status.host_empty   = (host_count_in == '0);
      status.host_bad     = host_bad_in;
      status.failed       = failed_in;
      status.too_long     = (position_in > POS_W'(PATH_LIMIT));
      status.double_colon = double_colon_in;
      status.digits_empty = (digit_count_in == '0);
      status.host_length  = host_count_wide[HOST_LEN_W-1:0];
      status.port_accum   = port_accum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && step_last)) begin
         position_ff     <= '0;
         phase_ff        <= PH_START;
         bracketed_ff    <= 1'b0;
         host_count_ff   <= '0;
         double_colon_ff <= 1'b0;
         digit_count_ff  <= '0;
         port_accum_ff   <= '0;
         failed_ff       <= 1'b0;
         host_bad_ff     <= 1'b0;
      end else if (step) begin
         position_ff     <= position_in;
         phase_ff        <= phase_in;
         bracketed_ff    <= bracketed_in;
         host_count_ff   <= host_count_in;
         double_colon_ff <= double_colon_in;
         digit_count_ff  <= digit_count_in;
         port_accum_ff   <= port_accum_in;
         failed_ff       <= failed_in;
         host_bad_ff     <= host_bad_in;
      end
   end

endmodule

/* src/host_port_path_parser.sv */
// Top level of the streaming host path parser.
//
// The parser takes one path character per clock, unless the input stalls,
// and gives one verdict transaction on each character marked as the last of
// its path. A character is registered on acceptance; when it is stepped, the
// path state is updated from that register and the verdict goes to the
// result register, which presents the result, and a new character can be
// taken in every cycle unless stalled. Only a result that is held by a
// stalled output and would be followed by another result stops the input.
// Writes of the default port take effect at once and must be made only while
// no path is in progress.
`include "host_port_path_parser_macros.svh"

module host_port_path_parser import hppp_pkg::*; #(
   parameter int MAX_HOST_CHARS  = 255,
   parameter int MAX_PORT_DIGITS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff;
   logic [CSR_W-1:0] default_port_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             step;
   logic             in_load;
   status_type       status;
   logic             ok;
   logic             local_host;
   logic [PORT_W-1:0] port;
   logic [PORT_W-1:0] base_port;

   logic             held_fail;
   logic             fail_clean;
   logic             held_local;
   logic             local_clean;
   logic             last_step;
   logic             last_held;

   hppp_tracker #(
      .MAX_HOST_CHARS  (MAX_HOST_CHARS),
      .MAX_PORT_DIGITS (MAX_PORT_DIGITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .step_last (in_data_ff.last_char),
      .step_char (in_data_ff.char_code),
      .status    (status)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_data_ff.last_char || out_free);
   assign in_load   = !in_valid_ff || step;
   assign req_stall = !in_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign base_port = PORT_W'(default_port_ff);

   always_comb begin
      ok         = 1'b1;
      local_host = 1'b0;
      port       = base_port;
      if (status.failed || status.too_long) begin
         ok = 1'b0;
      end else if (status.phase == PH_BRHOST) begin
         local_host = 1'b1;
      end else begin
         if (status.bracketed && status.host_empty) begin
            local_host = 1'b1;
         end else if (status.host_bad) begin
            ok = 1'b0;
         end
         if ((status.phase == PH_COLON) ||
             ((status.phase == PH_DIGITS) && status.digits_empty)) begin
            ok = 1'b0;
         end else if (status.phase == PH_DIGITS) begin
            port = status.port_accum;
            if (!status.double_colon && (status.port_accum <= DISPLAY_MAX)) begin
               port = status.port_accum + base_port;
            end
         end
      end

      rsp_in.path_ok       = ok;
      rsp_in.host_offset   = ok && status.bracketed;
      rsp_in.host_length   = (ok && !local_host) ? status.host_length : '0;
      rsp_in.use_localhost = ok && local_host;
      rsp_in.port_value    = ok ? port : '0;

      in_valid_in = in_load ? req_valid : in_valid_ff;

      if (step && in_data_ff.last_char) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         default_port_ff <= DEFAULT_PORT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            default_port_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (step && in_data_ff.last_char) begin
         rsp_ff <= rsp_in;
      end
   end

   assign held_fail   = rsp_valid_ff && !rsp_ff.path_ok;
   assign fail_clean  = !rsp_ff.host_offset && (rsp_ff.host_length == '0) &&
                        !rsp_ff.use_localhost && (rsp_ff.port_value == '0);
   assign held_local  = rsp_valid_ff && rsp_ff.use_localhost;
   assign local_clean = rsp_ff.path_ok && (rsp_ff.host_length == '0);
   assign last_step   = step && in_data_ff.last_char;
   assign last_held   = in_valid_ff && in_data_ff.last_char && rsp_valid_ff && rsp_stall;

   `HPPP_ASSERT_SAME(a_fail_fields_zero, clock, reset, held_fail, fail_clean)
   `HPPP_ASSERT_SAME(a_localhost_no_length, clock, reset, held_local, local_clean)
   `HPPP_ASSERT_NEXT(a_last_gives_result, clock, reset, last_step, rsp_valid_ff)
   `HPPP_ASSERT_SAME(a_stall_only_when_held, clock, reset, req_stall, last_held)

endmodule
